// ===== rtl/core/bsd_pkg.sv =====
`default_nettype none
package bsd_pkg;

  localparam int QueueDepthDefault = 4;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR   = 2'd1;
  localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  typedef enum logic [1:0] {
    SYM_DATA,
    SYM_PAD,
    SYM_SKIP,
    SYM_BAD
  } sym_class_t;

  typedef struct packed {
    sym_class_t sym_class;
    logic [5:0] value;
  } sym_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last;
  } out_t;

  // One queued piece of work: up to three bytes, then optionally a status.
  typedef struct packed {
    logic [1:0]  byte_count;
    logic [23:0] bytes;
    logic        has_status;
    logic [1:0]  status;
  } entry_t;

  function automatic sym_t classify(input logic [7:0] c);
    sym_t s;
    s.sym_class = SYM_DATA;
    s.value     = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      s.value = 6'd62;
    end else if (c == CHAR_SLASH) begin
      s.value = 6'd63;
    end else if (c == CHAR_PAD) begin
      s.sym_class = SYM_PAD;
    end else if (c == CHAR_CR || c == CHAR_LF) begin
      s.sym_class = SYM_SKIP;
    end else begin
      s.sym_class = SYM_BAD;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/base64_stream_decoder_unit.sv =====
`default_nettype none
// Streaming base64 decoder: one character per input item, one result per output item.
// The front takes a character in every cycle the entry queue has room, skips CR and
// LF, gathers symbols and pads into four-position quanta and, when a quantum closes or
// the item marks end of text, queues the 0 to 3 decoded bytes and the final status.
// The back drains the queue at one result per cycle, while the consumer is ready,
// through a registered output, so a stalled consumer never blocks the front until
// the queue is full. Sustained rate is one character per cycle while the queue has
// room: a quantum of four characters yields at most three bytes, and the back's single
// result per cycle is the only limit when quanta are short or texts end often. After
// an invalid character every further character of the text is dropped; bytes already
// emitted stand and the consumer discards them on a bad status.
module base64_stream_decoder_unit #(
  parameter int QueueDepth = bsd_pkg::QueueDepthDefault
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bsd_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bsd_pkg::out_t      out_data
);

  logic            q_push, q_full, q_pop, q_empty;
  bsd_pkg::entry_t q_in, q_head;

  // Classify characters and build quanta.
  bsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_in)
  );

  // Hold pending results between the two sides.
  bsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  // Emit bytes, then status, one item per cycle while the consumer is ready.
  bsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/bsd_front.sv =====
`default_nettype none
module bsd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire bsd_pkg::in_t     in_data,
  input  wire logic             q_full,
  output logic                  push,
  output bsd_pkg::entry_t       push_entry
);

  logic [23:0] sextets_r, sextets_nxt;
  logic [3:0]  pad_mask_r, pad_mask_nxt;
  logic [1:0]  sym_cnt_r, sym_cnt_nxt;
  logic        open_r, open_nxt;
  logic        err_r, err_nxt;

  bsd_pkg::sym_t sym;
  logic [23:0]   sext_v;
  logic [3:0]    pad_v;
  logic          accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    sym          = bsd_pkg::classify(in_data.char_in);
    sextets_nxt  = sextets_r;
    pad_mask_nxt = pad_mask_r;
    sym_cnt_nxt  = sym_cnt_r;
    open_nxt     = open_r;
    err_nxt      = err_r;
    sext_v       = sextets_r;
    pad_v        = pad_mask_r;
    push_entry   = '0;
    if (accept) begin
      if (!err_r) begin
        case (sym.sym_class)
          bsd_pkg::SYM_BAD: begin
            err_nxt = 1'b1;
          end
          bsd_pkg::SYM_SKIP: begin
            open_nxt = 1'b1;
          end
          default: begin
            open_nxt = 1'b1;
            if (sym.sym_class == bsd_pkg::SYM_PAD) begin
              pad_v[sym_cnt_r] = 1'b1;
            end else begin
              case (sym_cnt_r)
                2'd0:    sext_v[23:18] = sym.value;
                2'd1:    sext_v[17:12] = sym.value;
                2'd2:    sext_v[11:6]  = sym.value;
                default: sext_v[5:0]   = sym.value;
              endcase
            end
            if (sym_cnt_r == 2'd3) begin
              // Byte count follows the highest non-pad position.
              push_entry.bytes = sext_v;
              if (!pad_v[3]) begin
                push_entry.byte_count = 2'd3;
              end else if (!pad_v[2]) begin
                push_entry.byte_count = 2'd2;
              end else if (!pad_v[1]) begin
                push_entry.byte_count = 2'd1;
              end else begin
                push_entry.byte_count = 2'd0;
              end
              sextets_nxt  = '0;
              pad_mask_nxt = '0;
              sym_cnt_nxt  = 2'd0;
              open_nxt     = 1'b0;
            end else begin
              sextets_nxt  = sext_v;
              pad_mask_nxt = pad_v;
              sym_cnt_nxt  = sym_cnt_r + 2'd1;
            end
          end
        endcase
      end
      if (in_data.end_of_text) begin
        push_entry.has_status = 1'b1;
        if (err_nxt) begin
          push_entry.status = bsd_pkg::STATUS_BAD_CHAR;
        end else if (open_nxt) begin
          push_entry.status = bsd_pkg::STATUS_INCOMPLETE;
        end else begin
          push_entry.status = bsd_pkg::STATUS_OK;
        end
        sextets_nxt  = '0;
        pad_mask_nxt = '0;
        sym_cnt_nxt  = 2'd0;
        open_nxt     = 1'b0;
        err_nxt      = 1'b0;
      end
    end
  end

  // Queue only items that yield results.
  assign push = accept && (push_entry.byte_count != 2'd0 || push_entry.has_status);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sextets_r  <= '0;
      pad_mask_r <= '0;
      sym_cnt_r  <= '0;
      open_r     <= 1'b0;
      err_r      <= 1'b0;
    end else begin
      sextets_r  <= sextets_nxt;
      pad_mask_r <= pad_mask_nxt;
      sym_cnt_r  <= sym_cnt_nxt;
      open_r     <= open_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bsd_queue.sv =====
`default_nettype none
module bsd_queue #(
  parameter int Depth = bsd_pkg::QueueDepthDefault
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bsd_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output bsd_pkg::entry_t      head,
  output logic                 empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  bsd_pkg::entry_t slots_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full  = (count_r == DepthCnt);
  assign empty = (count_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bsd_back.sv =====
`default_nettype none
module bsd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bsd_pkg::entry_t head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bsd_pkg::out_t        out_data
);

  logic [1:0]    sub_r, sub_nxt;
  logic          out_valid_r, out_valid_nxt;
  bsd_pkg::out_t out_data_r, out_data_nxt;
  logic          emit;

  assign emit = !empty && (!out_valid_r || out_ready);

  always_comb begin
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (sub_r < head.byte_count) begin
        out_data_nxt.kind = bsd_pkg::KIND_DATA;
        case (sub_r)
          2'd0:    out_data_nxt.data_byte = head.bytes[23:16];
          2'd1:    out_data_nxt.data_byte = head.bytes[15:8];
          default: out_data_nxt.data_byte = head.bytes[7:0];
        endcase
        if (sub_r + 2'd1 == head.byte_count && !head.has_status) begin
          pop     = 1'b1;
          sub_nxt = 2'd0;
        end else begin
          sub_nxt = sub_r + 2'd1;
        end
      end else begin
        out_data_nxt.kind   = bsd_pkg::KIND_STATUS;
        out_data_nxt.status = head.status;
        out_data_nxt.last   = 1'b1;
        pop                 = 1'b1;
        sub_nxt             = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== bench/base64_stream_decoder_unit_test.sv =====
module base64_stream_decoder_unit_test;
  import bsd_pkg::*;

  localparam int unsigned TOTAL_ITEMS = 220;  // character count at which no further random texts are added
  localparam int unsigned HOLD_AT     = 60;   // result count that starts the long back-pressure
  localparam int unsigned LONG_HOLD   = 150;  // cycles the receiver keeps ready low then
  localparam int unsigned IDLE_LIMIT  = 2000; // cycles without any item moving before giving up
  localparam int unsigned TAIL_CYCLES = 8;    // cycles to run on after the last owed result

  // One character waiting for the driver, with its pacing.
  typedef struct packed {
    in_t        item;
    logic [3:0] gap;    // cycles to idle before offering it
    logic       drain;  // wait for every pending byte and status first
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  stim_t stim_q[$];
  out_t decoded_q[$];  // bytes and statuses the decoder still owes

  // Decoder state as predicted from the accepted characters.
  logic [23:0] quad_bits = '0;
  logic [3:0]  pad_bits = '0;
  logic [1:0]  quad_pos = '0;
  logic        quad_open = 1'b0;
  logic        bad_seen = 1'b0;

  int unsigned n_gen = 0;
  int unsigned n_texts = 0;
  int unsigned n_bad_texts = 0;
  int unsigned n_chars = 0;
  int unsigned n_results = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          drain_next = 1'b0;

  base64_stream_decoder_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Map a raw byte onto its symbol class and sextet. The low six bits of each
  // alphabet range differ from the sextet value by a fixed offset mod 64.
  function automatic sym_t char_to_sym(input logic [7:0] c);
    sym_t s;
    s.sym_class = SYM_BAD;
    s.value     = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.sym_class = SYM_DATA;
      s.value     = c[5:0] - 6'd1;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.sym_class = SYM_DATA;
      s.value     = c[5:0] - 6'd7;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.sym_class = SYM_DATA;
      s.value     = c[5:0] + 6'd4;
    end else if (c == CHAR_PLUS) begin
      s.sym_class = SYM_DATA;
      s.value     = 6'd62;
    end else if (c == CHAR_SLASH) begin
      s.sym_class = SYM_DATA;
      s.value     = 6'd63;
    end else if (c == CHAR_PAD) begin
      s.sym_class = SYM_PAD;
    end else if (c == CHAR_CR || c == CHAR_LF) begin
      s.sym_class = SYM_SKIP;
    end
    return s;
  endfunction

  // Advance the predicted decoder by one accepted character and queue what it owes.
  task automatic predict_decode(input in_t it);
    sym_t s;
    out_t r;
    int   nbytes;
    int   i;
    if (!bad_seen) begin
      s = char_to_sym(it.char_in);
      case (s.sym_class)
        SYM_BAD: begin
          bad_seen = 1'b1;
        end
        SYM_SKIP: begin
          quad_open = 1'b1;
        end
        default: begin
          quad_open = 1'b1;
          if (s.sym_class == SYM_PAD) begin
            pad_bits[quad_pos] = 1'b1;
          end else begin
            quad_bits[23 - 6 * quad_pos -: 6] = s.value;
          end
          if (quad_pos == 2'd3) begin
            // byte count is the highest non-pad position; position 0 alone gives none
            nbytes = 0;
            for (i = 3; i >= 1; i--) begin
              if (!pad_bits[i] && nbytes == 0) nbytes = i;
            end
            for (i = 0; i < nbytes; i++) begin
              r.kind      = KIND_DATA;
              r.data_byte = quad_bits[23 - 8 * i -: 8];
              r.status    = STATUS_OK;
              r.last      = 1'b0;
              decoded_q.push_back(r);
            end
            quad_bits = '0;
            pad_bits  = '0;
            quad_pos  = '0;
            quad_open = 1'b0;
          end else begin
            quad_pos = quad_pos + 2'd1;
          end
        end
      endcase
    end
    if (it.end_of_text) begin
      r.kind      = KIND_STATUS;
      r.data_byte = '0;
      r.last      = 1'b1;
      if (bad_seen) begin
        r.status = STATUS_BAD_CHAR;
        n_bad_texts++;
      end else if (quad_open) begin
        r.status = STATUS_INCOMPLETE;
      end else begin
        r.status = STATUS_OK;
      end
      decoded_q.push_back(r);
      quad_bits = '0;
      pad_bits  = '0;
      quad_pos  = '0;
      quad_open = 1'b0;
      bad_seen  = 1'b0;
    end
  endtask

  // Queue one character; every third stretch of 40 goes out back to back.
  task automatic add_char(input logic [7:0] c, input bit eot);
    stim_t st;
    st.item.char_in     = c;
    st.item.end_of_text = eot;
    st.gap   = ((n_gen / 40) % 3 == 1) ? 4'd0 : 4'($urandom_range(0, 8));
    st.drain = drain_next;
    drain_next = 1'b0;
    stim_q.push_back(st);
    n_gen++;
    if (eot) n_texts++;
  endtask

  task automatic add_text(input string s, input bit eot);
    int i;
    for (i = 0; i < s.len(); i++) begin
      add_char(s[i], eot && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] sym_char(input int unsigned v);
    logic [7:0] c;
    if (v < 26) c = 8'h41 + v[7:0];
    else if (v < 52) c = 8'h61 + v[7:0] - 8'd26;
    else if (v < 62) c = 8'h30 + v[7:0] - 8'd52;
    else if (v == 62) c = CHAR_PLUS;
    else c = CHAR_SLASH;
    return c;
  endfunction

  // Driver: offer the head of the pending queue once its gap has run out.
  int unsigned wait_left = 0;
  always @(posedge clk) begin : drive
    logic offering;
    offering = in_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_decode(in_data);
        n_chars++;
        offering = 1'b0;
      end
      if (!offering && stim_q.size() != 0) begin
        if (stim_q[0].drain && decoded_q.size() != 0) begin
          // hold until the decoder has delivered everything owed
        end else if (wait_left < stim_q[0].gap) begin
          wait_left++;
        end else begin
          in_data <= stim_q[0].item;
          stim_q.pop_front();
          wait_left = 0;
          offering  = 1'b1;
        end
      end
    end
    in_valid <= offering;
  end

  // Monitor: take results, check them against the oldest owed one, pace out_ready.
  int unsigned rest_left = 0;
  int unsigned hold_left = 0;
  bit          held = 1'b0;
  always @(posedge clk) begin : receive
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0b byte=%02h status=%0d last=%0b",
                   $time, out_data.kind, out_data.data_byte, out_data.status, out_data.last);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data.kind !== want.kind) begin
            $display("%0t: kind expected %0b got %0b", $time, want.kind, out_data.kind);
            errors++;
          end
          if (out_data.data_byte !== want.data_byte) begin
            $display("%0t: data_byte expected %02h got %02h",
                     $time, want.data_byte, out_data.data_byte);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_data.status);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $display("%0t: last expected %0b got %0b", $time, want.last, out_data.last);
            errors++;
          end
        end
        n_results++;
        if (!held && n_results == HOLD_AT) begin
          // stall long enough for the entry queue to fill and in_ready to drop
          held      = 1'b1;
          hold_left = LONG_HOLD;
        end else begin
          rest_left = ((n_results / 30) % 3 == 1) ? 0 : $urandom_range(0, 8);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rest_left != 0) begin
        rest_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up when no item moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  text[$];
    int unsigned shape;
    int unsigned nq;
    int unsigned q;
    int unsigned p;
    int unsigned k;
    bit          mid_drain;
    mid_drain = 1'b0;

    // Directed texts: full quantum, pads with an embedded CR, pad in front
    // plus alphabet edges and a trailing CR, invalid bytes 0xFF and 0x00
    // (the latter as the final character), a lone symbol, a lone LF, all pads.
    add_text("TWFu", 1'b1);
    add_text("TQ\r==", 1'b1);
    add_text("=/+z\r", 1'b1);
    add_char("9", 1'b0);
    add_char(8'hFF, 1'b0);
    add_char("Z", 1'b1);
    add_char(8'h00, 1'b1);
    add_text("A", 1'b1);
    add_char(CHAR_LF, 1'b1);
    add_text("====", 1'b1);

    // Random texts: mostly well formed with random symbols, pads and line
    // breaks; the rest carry a stray byte, a short tail or a trailing break.
    drain_next = 1'b1;
    while (n_gen < TOTAL_ITEMS) begin
      if (!mid_drain && n_gen >= 150) begin
        mid_drain  = 1'b1;
        drain_next = 1'b1;
      end
      text.delete();
      shape = $urandom_range(0, 9);
      nq    = $urandom_range(1, 3);
      for (q = 0; q < nq; q++) begin
        for (p = 0; p < 4; p++) begin
          if ($urandom_range(0, 15) == 0) text.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
          if ($urandom_range(0, 5) == 0) text.push_back(CHAR_PAD);
          else text.push_back(sym_char($urandom_range(0, 63)));
        end
      end
      if (shape == 7) begin
        text.push_back(8'($urandom_range(0, 255)));
        k = $urandom_range(0, 5);
        for (p = 0; p < k; p++) text.push_back(sym_char($urandom_range(0, 63)));
      end else if (shape == 8) begin
        k = $urandom_range(1, 3);
        for (p = 0; p < k; p++) text.push_back(sym_char($urandom_range(0, 63)));
      end else if (shape == 9) begin
        text.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end
      for (p = 0; p < text.size(); p++) add_char(text[p], p == text.size() - 1);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // drain the input side, then every owed result, then a short tail
    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Decoded %0d characters in %0d texts (%0d with a bad character) into %0d results",
             n_chars, n_texts, n_bad_texts, n_results);
    $display("with pads, line breaks, short tails, a long output stall and drain pauses");
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
